// ===== sv/move_to_front_coder_assert.svh =====
// Assertion macros for the move-to-front coder.
// Every check is clocked on i_clk and is off while i_rst_n is low.
`ifndef MOVE_TO_FRONT_CODER_ASSERT_SVH
`define MOVE_TO_FRONT_CODER_ASSERT_SVH

// Same-cycle implication.
`define MTF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("move_to_front_coder: assertion failed");

// Next-cycle implication.
`define MTF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("move_to_front_coder: assertion failed");

`endif

// ===== sv/mtf_pkg.sv =====
package mtf_pkg;

    // Fixed field widths of the ports.
    localparam int SYMBOL_W = 5;
    localparam int CODE_W   = 5;

    // Per-cell control, driven by the top level.
    typedef struct packed {
        logic load;     // a word is accepted this cycle
        logic restore;  // use identity value instead of stored entry
        logic shift;    // take the neighbor's value
    } t_cell_ctl;

endpackage

// ===== sv/mtf_cell.sv =====
module mtf_cell #(
    parameter int ENTRY_W = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [ENTRY_W-1:0]   i_home,
    input  logic [ENTRY_W-1:0]   i_prev,
    input  logic [ENTRY_W-1:0]   i_key,
    input  mtf_pkg::t_cell_ctl   i_ctl,
    output logic [ENTRY_W-1:0]   o_cur,
    output logic [ENTRY_W-1:0]   o_stored,
    output logic                 o_hit
);

    logic [ENTRY_W-1:0] r_entry;
    logic [ENTRY_W-1:0] n_entry;

    // Current view of the entry, with a pending restore applied.
    assign o_cur    = i_ctl.restore ? i_home : r_entry;
    assign o_stored = r_entry;
    assign o_hit    = (o_cur == i_key);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.load) begin
            n_entry = i_ctl.shift ? i_prev : o_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= i_home;
        end else begin
            r_entry <= n_entry;
        end
    end

endmodule

// ===== sv/move_to_front_coder.sv =====
// Channel | Direction | Handshake                  | Payload
// in      | input     | i_in_valid / o_in_ready    | i_symbol[4:0], i_first
// out     | output    | o_out_valid / i_out_ready  | o_code[4:0], o_invalid
// cfg     | input     | i_cfg_we (no wait)         | i_cfg_wdata (decode_mode)
//
// One word per cycle when not stalled; a result follows in the cycle after
// acceptance. The row of cells sets the rate: all compare and shift at once.
// Reset (synchronous, active low) loads identity order and selects encode mode.
// A stalled result holds in the output register; input is taken whenever that
// register is empty or being drained in the same cycle.
`include "move_to_front_coder_assert.svh"

module move_to_front_coder #(
    parameter int ALPHABET = 26
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [mtf_pkg::SYMBOL_W-1:0]  i_symbol,
    input  logic                          i_first,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mtf_pkg::CODE_W-1:0]    o_code,
    output logic                          o_invalid
);

    // Entry width follows the alphabet; comparisons use one bit more than the
    // wider of it and the symbol field, so ALPHABET itself always fits.
    localparam int W     = $clog2(ALPHABET);
    localparam int CMP_W = ((W > mtf_pkg::SYMBOL_W) ? W : mtf_pkg::SYMBOL_W) + 1;

    logic                          r_decode_mode;
    logic                          r_out_valid;
    logic [mtf_pkg::CODE_W-1:0]    r_code;
    logic                          r_invalid;
    logic [mtf_pkg::CODE_W-1:0]    n_code;

    logic                          accept;
    logic [CMP_W-1:0]              sym_ext;
    logic                          sym_ok;
    logic [W-1:0]                  key;
    logic [W-1:0]                  pos_enc;
    logic [W-1:0]                  pos;
    logic [W-1:0]                  sel_entry;
    logic [W-1:0]                  front_val;
    logic [CMP_W-1:0]              code_full;

    logic [W-1:0]                  cur    [ALPHABET];
    logic [W-1:0]                  stored [ALPHABET];
    logic [W-1:0]                  prev   [ALPHABET];
    logic [ALPHABET-1:0]           hit;
    mtf_pkg::t_cell_ctl            ctl    [ALPHABET];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign sym_ext = CMP_W'(i_symbol);
    assign sym_ok  = (sym_ext < CMP_W'(ALPHABET));
    assign key     = sym_ext[W-1:0];

    // Encode: position of the single matching cell (none found gives 0).
    always_comb begin
        pos_enc = '0;
        for (int i = 0; i < ALPHABET; i++) begin
            if (hit[i]) begin
                pos_enc = pos_enc | W'(i);
            end
        end
    end

    // Decode: the symbol is the position; read that cell.
    assign sel_entry = cur[key];
    assign pos       = r_decode_mode ? key : pos_enc;
    assign front_val = r_decode_mode ? sel_entry : key;

    assign code_full = r_decode_mode ? CMP_W'(sel_entry) : CMP_W'(pos_enc);
    assign n_code    = sym_ok ? code_full[mtf_pkg::CODE_W-1:0] : '0;

    // Row of cells: cell 0 takes the front value, each later cell takes its
    // left neighbor when it sits at or before the moved position.
    for (genvar g = 0; g < ALPHABET; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign prev[g] = front_val;
        end else begin : g_body
            assign prev[g] = cur[g-1];
        end

        assign ctl[g].load    = accept;
        assign ctl[g].restore = i_first;
        assign ctl[g].shift   = sym_ok && (W'(g) <= pos);

        mtf_cell #(
            .ENTRY_W (W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_home   (W'(g)),
            .i_prev   (prev[g]),
            .i_key    (key),
            .i_ctl    (ctl[g]),
            .o_cur    (cur[g]),
            .o_stored (stored[g]),
            .o_hit    (hit[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_mode <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_decode_mode <= i_cfg_wdata;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, no reset needed.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_code    <= n_code;
            r_invalid <= !sym_ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_code      = r_code;
    assign o_invalid   = r_invalid;

    // An invalid word always reports code 0.
    `MTF_ASSERT_NOW(a_invalid_code_zero, o_out_valid && o_invalid, o_code == '0)
    // Every accepted word produces a pending result.
    `MTF_ASSERT_NEXT(a_accept_gives_result, accept, o_out_valid)
    // A valid word leaves its symbol at the front of the list.
    `MTF_ASSERT_NEXT(a_front_updated, accept && sym_ok, stored[0] == $past(front_val))

endmodule

// ===== sim/move_to_front_coder_tb.sv =====
`timescale 1ns / 100ps

// Self-checking bench for move_to_front_coder.
// A local recency-list model predicts every result at the edge where its
// input word is accepted. A separate process compares each accepted result
// word with the oldest prediction.
module move_to_front_coder_tb;

    localparam int ALPHABET    = 26;
    localparam int CYCLE_LIMIT = 200000;  // many times the slowest legal run
    localparam int REPORT_MAX  = 10;

    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } t_mtf_mode;

    // Receiver stall styles.
    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC
    } t_rx_style;

    typedef struct packed {
        logic [mtf_pkg::CODE_W-1:0] code;
        logic                       invalid;
    } t_mtf_result;

    // DUT pins; the driven ones are all known from time zero.
    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         cfg_we    = 1'b0;
    logic                         cfg_wdata = 1'b0;
    logic                         in_valid  = 1'b0;
    logic [mtf_pkg::SYMBOL_W-1:0] in_symbol = '0;
    logic                         in_first  = 1'b0;
    logic                         out_ready = 1'b0;
    wire                          in_ready;
    wire                          out_valid;
    wire  [mtf_pkg::CODE_W-1:0]   out_code;
    wire                          out_invalid;

    // Model state: recency list and current mode.
    logic [mtf_pkg::SYMBOL_W-1:0] recency_order[ALPHABET];
    t_mtf_mode                    model_mode;

    // Predicted result words, oldest first.
    t_mtf_result pending_codes[$];

    int        mismatch_count = 0;
    int        cycle_count    = 0;
    t_rx_style rx_style       = RX_ALWAYS;
    int        rx_hold_req    = 0;   // hold-off length handed to the receiver
    bit        sender_idles   = 1'b0;
    int        burst_left     = 0;

    move_to_front_coder #(
        .ALPHABET(ALPHABET)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_symbol   (in_symbol),
        .i_first    (in_first),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_code     (out_code),
        .o_invalid  (out_invalid)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------

    function automatic void restore_order();
        int i;
        for (i = 0; i < ALPHABET; i++) recency_order[i] = mtf_pkg::SYMBOL_W'(i);
    endfunction

    // Work out the result of one accepted word and update the list.
    // Invalid symbols leave the list alone, but a restart still applies.
    function automatic t_mtf_result predict_mtf(input logic [mtf_pkg::SYMBOL_W-1:0] sym,
                                                input logic restart);
        t_mtf_result                  res;
        int                           pos;
        int                           i;
        bit                           found;
        logic [mtf_pkg::SYMBOL_W-1:0] entry;
        res = '0;
        if (restart) restore_order();
        if (sym >= ALPHABET) begin
            res.invalid = 1'b1;
            return res;
        end
        if (model_mode == MODE_DECODE) begin
            pos   = sym;
            entry = recency_order[sym];
        end else begin
            // Linear search; the list is a permutation so the symbol is there.
            pos   = 0;
            found = 1'b0;
            entry = sym;
            for (i = 0; i < ALPHABET; i++) begin
                if (!found && recency_order[i] == sym) begin
                    pos   = i;
                    found = 1'b1;
                end
            end
        end
        res.code = (model_mode == MODE_DECODE) ? entry : mtf_pkg::CODE_W'(pos);
        // Entries ahead of the hit slide back one place.
        for (i = pos; i > 0; i--) recency_order[i] = recency_order[i-1];
        recency_order[0] = entry;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Burst/gap pacing after each accepted word. Valid is only lowered when
    // a real gap follows, so it never drops and rises in one time step.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap = sender_idles ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    // Offer one word and hold it until the block takes it.
    task automatic send_word(input logic [mtf_pkg::SYMBOL_W-1:0] sym, input logic restart);
        in_valid  <= 1'b1;
        in_symbol <= sym;
        in_first  <= restart;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_codes = {pending_codes, predict_mtf(sym, restart)};
        pace_sender();
    endtask

    // Stop offering and let every predicted result come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_codes.size() != 0) @(posedge clk);
    endtask

    // Mode register; only called with the block idle.
    task automatic write_mode(input t_mtf_mode mode);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we     <= 1'b0;
        model_mode = mode;
    endtask

    // Recent (small) values for nearly half the picks, which is what real streams look like,
    // plus uniform picks and the odd out-of-range symbol.
    function automatic logic [mtf_pkg::SYMBOL_W-1:0] pick_symbol();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return mtf_pkg::SYMBOL_W'($urandom_range(0, 3));
        if (roll < 92) return mtf_pkg::SYMBOL_W'($urandom_range(0, ALPHABET - 1));
        return mtf_pkg::SYMBOL_W'($urandom_range(ALPHABET, 31));
    endfunction

    // Strings that start with first set, then plain words; some stray words
    // with random first/symbol in between.
    task automatic send_strings(input int n_words);
        int sent;
        int len;
        int k;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(0, 7) == 0) begin
                send_word(mtf_pkg::SYMBOL_W'($urandom_range(0, 31)),
                          1'($urandom_range(0, 1)));
                sent++;
            end else begin
                len = $urandom_range(1, 40);
                for (k = 0; k < len; k++) send_word(pick_symbol(), k == 0);
                sent += len;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Encode corners: edges of the alphabet, repeats, both invalid forms,
    // a restart carried on an invalid word.
    task automatic test_encode_corners();
        rx_style     = RX_ALWAYS;
        sender_idles = 1'b0;
        send_word(5'd0,  1'b1);
        send_word(5'd25, 1'b0);
        send_word(5'd25, 1'b0);
        send_word(5'd0,  1'b0);
        send_word(5'd31, 1'b0);
        send_word(5'd26, 1'b0);
        send_word(5'd30, 1'b1);   // restart on an invalid symbol
        send_word(5'd25, 1'b0);   // must see identity order again
        send_word(5'd13, 1'b0);
        send_word(5'd0,  1'b1);
        wait_drained();
    endtask

    task automatic test_decode_corners();
        write_mode(MODE_DECODE);
        send_word(5'd25, 1'b1);
        send_word(5'd0,  1'b0);
        send_word(5'd1,  1'b0);
        send_word(5'd31, 1'b1);   // invalid, list restored anyway
        send_word(5'd0,  1'b0);
        send_word(5'd25, 1'b0);
        send_word(5'd21, 1'b0);
        send_word(5'd27, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_encode();
        write_mode(MODE_ENCODE);
        rx_style     = RX_RANDOM;
        sender_idles = 1'b1;
        send_strings(500);
        wait_drained();
    endtask

    task automatic test_random_decode();
        write_mode(MODE_DECODE);
        rx_style     = RX_PERIODIC;
        sender_idles = 1'b1;
        send_strings(500);
        wait_drained();
    endtask

    // Receiver goes quiet for a long stretch while the sender keeps pushing,
    // so the output register fills and input ready drops.
    task automatic test_backpressure();
        rx_style     = RX_RANDOM;
        sender_idles = 1'b0;
        rx_hold_req  = 300;
        send_strings(60);
        wait_drained();
    endtask

    // Mode flips between drained phases, list state carries across.
    task automatic test_mode_switching();
        int k;
        sender_idles = 1'b1;
        for (k = 0; k < 10; k++) begin
            rx_style = (k % 2 == 0) ? RX_ALWAYS : RX_RANDOM;
            write_mode(k % 2 == 0 ? MODE_ENCODE : MODE_DECODE);
            send_strings(35);
            wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------

    initial begin : receiver
        int hold_left;
        int tick;
        hold_left = 0;
        tick      = 0;
        forever begin
            @(posedge clk);
            tick++;
            if (rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                case (rx_style)
                    RX_RANDOM:   out_ready <= ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: out_ready <= ((tick % 7) >= 2);
                    default:     out_ready <= 1'b1;
                endcase
            end
        end
    end

    // Every accepted result word is matched against the oldest prediction.
    always @(posedge clk) begin : result_check
        t_mtf_result want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_codes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result word: code=%0d invalid=%0b",
                             out_code, out_invalid);
            end else begin
                want = pending_codes.pop_front();
                if (want.code !== out_code || want.invalid !== out_invalid) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("result mismatch: code exp %0d got %0d, invalid exp %0b got %0b",
                                 want.code, out_code, want.invalid, out_invalid);
                end
            end
        end
    end

    // Watchdog.
    initial begin
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        model_mode = MODE_ENCODE;
        restore_order();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_encode_corners();
        test_decode_corners();
        test_random_encode();
        test_random_decode();
        test_backpressure();
        test_mode_switching();

        wait_drained();
        repeat (5) @(posedge clk);   // catch any stray result word
        if (mismatch_count == 0 && pending_codes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
